[rtl/core/tcb_pkg.sv]
// Shared types and constants for the text cell buffer core.
// Holds character and key codes, the cursor unit opcodes and the sequencer states.
// No dependencies.
`default_nettype none

package tcb_pkg;

    // Default sizing, handed to the top level parameters.
    localparam int MAX_COLS_DEFAULT = 128;
    localparam int MAX_ROWS_DEFAULT = 64;
    localparam int TAB_STOP_DEFAULT = 8;

    // Grid size after reset, before any clamping to the maximum grid.
    localparam int COLS_RESET_DEFAULT = 80;
    localparam int ROWS_RESET_DEFAULT = 25;

    localparam int CHAR_W = 16;

    // Cell address width at the default grid size, used as the RAM default.
    localparam int CELL_AW_DEFAULT =
        $clog2(MAX_COLS_DEFAULT) + $clog2(MAX_ROWS_DEFAULT);

    // Item function codes.
    localparam logic [1:0] FUNC_NAV  = 2'd0;
    localparam logic [1:0] FUNC_CHAR = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_COLUMNS_IN_USE = 2'd0;
    localparam logic [1:0] REG_ROWS_IN_USE    = 2'd1;

    // Control characters.
    localparam logic [CHAR_W-1:0] CH_BS    = 16'h0008;
    localparam logic [CHAR_W-1:0] CH_TAB   = 16'h0009;
    localparam logic [CHAR_W-1:0] CH_LF    = 16'h000A;
    localparam logic [CHAR_W-1:0] CH_CR    = 16'h000D;
    localparam logic [CHAR_W-1:0] CH_ESC   = 16'h001B;
    localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;

    // Navigation key codes.
    localparam logic [CHAR_W-1:0] KEY_PGUP  = 16'h0021;
    localparam logic [CHAR_W-1:0] KEY_PGDN  = 16'h0022;
    localparam logic [CHAR_W-1:0] KEY_END   = 16'h0023;
    localparam logic [CHAR_W-1:0] KEY_HOME  = 16'h0024;
    localparam logic [CHAR_W-1:0] KEY_LEFT  = 16'h0025;
    localparam logic [CHAR_W-1:0] KEY_UP    = 16'h0026;
    localparam logic [CHAR_W-1:0] KEY_RIGHT = 16'h0027;
    localparam logic [CHAR_W-1:0] KEY_DOWN  = 16'h0028;
    localparam logic [CHAR_W-1:0] KEY_DEL   = 16'h002E;

    typedef enum logic [3:0] {
        ALU_HOLD,
        ALU_HOME,
        ALU_END,
        ALU_PGUP,
        ALU_PGDN,
        ALU_LEFT,
        ALU_RIGHT,
        ALU_UP,
        ALU_DOWN,
        ALU_ADVANCE,
        ALU_NEWLINE,
        ALU_RETURN
    } alu_op_t;

    typedef struct packed {
        logic at_last_col;
        logic tab_aligned;
    } alu_flags_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_PUT,
        S_DEL_RD,
        S_DEL_WR,
        S_DEL_END,
        S_DONE
    } fsm_state_t;

endpackage

`default_nettype wire

[rtl/core/text_cell_buffer_with_cursor_core.sv]
// Each input beat runs through the sequencer states: a key, a read or a zero repeat count go
// from execute to done; line feed and return step the cursor in execute once per repetition,
// other characters write one cell per repetition, a tab writes spaces up to the next tab stop,
// and a delete key or a backspace shifts the rest of the row left one cell at a time.
// One item at a time: s_ready is high only when idle.
// Reset, Escape and a write to a grid size register run a clearing pass; no beat is taken then.
`default_nettype none

module text_cell_buffer_with_cursor_core import tcb_pkg::*; #(
    parameter int MAX_COLS = MAX_COLS_DEFAULT,
    parameter int MAX_ROWS = MAX_ROWS_DEFAULT,
    parameter int TAB_STOP = TAB_STOP_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [15:0] s_code,
    input  logic [15:0] s_repeat_count,
    input  logic [6:0]  s_read_col,
    input  logic [5:0]  s_read_row,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_cursor_col,
    output logic [5:0]  m_cursor_row,
    output logic [15:0] m_cell_char
);

    localparam int CW   = $clog2(MAX_COLS);
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int CNW  = $clog2(MAX_COLS + 1);
    localparam int RNW  = $clog2(MAX_ROWS + 1);
    localparam int AW   = CW + RW;
    localparam int CCW  = (CNW > 7) ? CNW : 7;
    localparam int RCW  = (RNW > 6) ? RNW : 6;
    localparam int COLS_RESET = (COLS_RESET_DEFAULT > MAX_COLS) ? MAX_COLS : COLS_RESET_DEFAULT;
    localparam int ROWS_RESET = (ROWS_RESET_DEFAULT > MAX_ROWS) ? MAX_ROWS : ROWS_RESET_DEFAULT;

    fsm_state_t        state_reg, state_next;
    logic [CW-1:0]     cursor_x_reg, cursor_x_next;
    logic [RW-1:0]     cursor_y_reg, cursor_y_next;
    logic [CNW-1:0]    cols_reg, cols_next;
    logic [RNW-1:0]    rows_reg, rows_next;
    logic [1:0]        func_reg, func_next;
    logic [15:0]       code_reg, code_next;
    logic [15:0]       count_reg, count_next;
    logic [6:0]        rd_col_reg, rd_col_next;
    logic [5:0]        rd_row_reg, rd_row_next;
    logic [CW-1:0]     scan_reg, scan_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    logic              clr_item_reg, clr_item_next;
    logic              m_valid_reg, m_valid_next;
    logic [6:0]        m_col_reg, m_col_next;
    logic [5:0]        m_row_reg, m_row_next;
    logic [15:0]       m_char_reg, m_char_next;

    alu_op_t           alu_op;
    logic [CW-1:0]     alu_x;
    logic [CW-1:0]     alu_x_out;
    logic [RW-1:0]     alu_y_out;
    alu_flags_t        alu_flags;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CHAR_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [CHAR_W-1:0] mem_rdata;

    logic [CCW-1:0]    rd_col_ext, cols_ext, rd_col_clamp;
    logic [RCW-1:0]    rd_row_ext, rows_ext, rd_row_clamp;
    logic [8:0]        cfg_cols_v;
    logic [7:0]        cfg_rows_v;

    tcb_cursor_alu #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_alu (
        .op    (alu_op),
        .x_in  (alu_x),
        .y_in  (cursor_y_reg),
        .cols  (cols_reg),
        .rows  (rows_reg),
        .x_out (alu_x_out),
        .y_out (alu_y_out),
        .flags (alu_flags)
    );

    tcb_cell_ram #(
        .AW (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // The row walk of a delete runs the shared unit on the scan pointer.
    assign alu_x = (state_reg == S_DEL_RD || state_reg == S_DEL_WR) ? scan_reg : cursor_x_reg;

    assign rd_col_ext   = CCW'(rd_col_reg);
    assign cols_ext     = CCW'(cols_reg);
    assign rd_col_clamp = (rd_col_ext >= cols_ext) ? cols_ext - CCW'(1) : rd_col_ext;
    assign rd_row_ext   = RCW'(rd_row_reg);
    assign rows_ext     = RCW'(rows_reg);
    assign rd_row_clamp = (rd_row_ext >= rows_ext) ? rows_ext - RCW'(1) : rd_row_ext;

    always_comb begin
        cfg_cols_v = {1'b0, cfg_wdata};
        if (cfg_cols_v == '0) cfg_cols_v = 9'd1;
        if (cfg_cols_v > 9'(MAX_COLS)) cfg_cols_v = 9'(MAX_COLS);
        cfg_rows_v = {1'b0, cfg_wdata[6:0]};
        if (cfg_rows_v == '0) cfg_rows_v = 8'd1;
        if (cfg_rows_v > 8'(MAX_ROWS)) cfg_rows_v = 8'(MAX_ROWS);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            cols_reg     <= CNW'(COLS_RESET);
            rows_reg     <= RNW'(ROWS_RESET);
            clr_addr_reg <= '0;
            clr_item_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            cols_reg     <= cols_next;
            rows_reg     <= rows_next;
            clr_addr_reg <= clr_addr_next;
            clr_item_reg <= clr_item_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg   <= func_next;
        code_reg   <= code_next;
        count_reg  <= count_next;
        rd_col_reg <= rd_col_next;
        rd_row_reg <= rd_row_next;
        scan_reg   <= scan_next;
        m_col_reg  <= m_col_next;
        m_row_reg  <= m_row_next;
        m_char_reg <= m_char_next;
    end

    always_comb begin
        state_next    = state_reg;
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        cols_next     = cols_reg;
        rows_next     = rows_reg;
        func_next     = func_reg;
        code_next     = code_reg;
        count_next    = count_reg;
        rd_col_next   = rd_col_reg;
        rd_row_next   = rd_row_reg;
        scan_next     = scan_reg;
        clr_addr_next = clr_addr_reg;
        clr_item_next = clr_item_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_col_next    = m_col_reg;
        m_row_next    = m_row_reg;
        m_char_next   = m_char_reg;
        alu_op        = ALU_HOLD;
        mem_we        = 1'b0;
        mem_waddr     = {cursor_y_reg, cursor_x_reg};
        mem_wdata     = CH_SPACE;
        mem_re        = 1'b0;
        mem_raddr     = {RW'(rd_row_clamp), CW'(rd_col_clamp)};

        unique case (state_reg)
            S_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == '1) begin
                    state_next = clr_item_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    func_next   = s_func;
                    code_next   = s_code;
                    count_next  = s_repeat_count;
                    rd_col_next = s_read_col;
                    rd_row_next = s_read_row;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (func_reg)
                    FUNC_NAV: begin
                        state_next = S_DONE;
                        unique case (code_reg)
                            KEY_HOME:  alu_op = ALU_HOME;
                            KEY_END:   alu_op = ALU_END;
                            KEY_PGUP:  alu_op = ALU_PGUP;
                            KEY_PGDN:  alu_op = ALU_PGDN;
                            KEY_LEFT:  alu_op = ALU_LEFT;
                            KEY_RIGHT: alu_op = ALU_RIGHT;
                            KEY_UP:    alu_op = ALU_UP;
                            KEY_DOWN:  alu_op = ALU_DOWN;
                            KEY_DEL: begin
                                scan_next  = cursor_x_reg;
                                state_next = S_DEL_RD;
                            end
                            default: begin
                            end
                        endcase
                        cursor_x_next = alu_x_out;
                        cursor_y_next = alu_y_out;
                    end
                    FUNC_CHAR: begin
                        if (count_reg == '0) begin
                            state_next = S_DONE;
                        end else begin
                            unique case (code_reg) inside
                                CH_ESC: begin
                                    // Repeating a clear changes nothing more, so it runs once.
                                    cursor_x_next = '0;
                                    cursor_y_next = '0;
                                    clr_addr_next = '0;
                                    clr_item_next = 1'b1;
                                    state_next    = S_CLEAR;
                                end
                                CH_BS: begin
                                    // At column 0 every remaining repetition is a no-op.
                                    if (cursor_x_reg != '0) begin
                                        alu_op        = ALU_LEFT;
                                        cursor_x_next = alu_x_out;
                                        scan_next     = alu_x_out;
                                        state_next    = S_DEL_RD;
                                    end else begin
                                        state_next = S_DONE;
                                    end
                                end
                                CH_LF, CH_CR: begin
                                    alu_op        = (code_reg == CH_CR) ? ALU_RETURN : ALU_NEWLINE;
                                    cursor_x_next = alu_x_out;
                                    cursor_y_next = alu_y_out;
                                    if (count_reg == 16'd1) begin
                                        state_next = S_DONE;
                                    end else begin
                                        count_next = count_reg - 16'd1;
                                    end
                                end
                                default: state_next = S_PUT;
                            endcase
                        end
                    end
                    FUNC_READ: begin
                        mem_re     = 1'b1;
                        state_next = S_DONE;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_PUT: begin
                mem_we        = 1'b1;
                mem_wdata     = (code_reg == CH_TAB) ? CH_SPACE : code_reg;
                alu_op        = ALU_ADVANCE;
                cursor_x_next = alu_x_out;
                cursor_y_next = alu_y_out;
                if (code_reg != CH_TAB || alu_flags.tab_aligned) begin
                    if (count_reg == 16'd1) begin
                        state_next = S_DONE;
                    end else begin
                        count_next = count_reg - 16'd1;
                        state_next = S_EXEC;
                    end
                end
            end
            S_DEL_RD: begin
                alu_op = ALU_RIGHT;
                if (alu_flags.at_last_col) begin
                    state_next = S_DEL_END;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = {cursor_y_reg, alu_x_out};
                    state_next = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = {cursor_y_reg, scan_reg};
                mem_wdata  = mem_rdata;
                alu_op     = ALU_RIGHT;
                scan_next  = alu_x_out;
                state_next = S_DEL_RD;
            end
            S_DEL_END: begin
                alu_op    = ALU_END;
                mem_we    = 1'b1;
                mem_waddr = {cursor_y_reg, alu_x_out};
                if (func_reg != FUNC_CHAR || count_reg == 16'd1) begin
                    state_next = S_DONE;
                end else begin
                    count_next = count_reg - 16'd1;
                    state_next = S_EXEC;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_col_next   = 7'(cursor_x_reg);
                    m_row_next   = 6'(cursor_y_reg);
                    m_char_next  = (func_reg == FUNC_READ) ? mem_rdata : '0;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // A write to the column or row register resizes the grid, homes the cursor and restarts the clear.
        if (cfg_we) begin
            unique case (cfg_index)
                REG_COLUMNS_IN_USE: begin
                    cols_next     = CNW'(cfg_cols_v);
                    cursor_x_next = '0;
                    cursor_y_next = '0;
                    clr_addr_next = '0;
                    clr_item_next = 1'b0;
                    state_next    = S_CLEAR;
                end
                REG_ROWS_IN_USE: begin
                    rows_next     = RNW'(cfg_rows_v);
                    cursor_x_next = '0;
                    cursor_y_next = '0;
                    clr_addr_next = '0;
                    clr_item_next = 1'b0;
                    state_next    = S_CLEAR;
                end
                default: begin
                end
            endcase
        end
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_cursor_col = m_col_reg;
    assign m_cursor_row = m_row_reg;
    assign m_cell_char  = m_char_reg;

    a_cursor_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cursor_x_reg < cols_reg) && (cursor_y_reg < rows_reg))
        else $error("cursor left the grid");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again before the item finished");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result beat raised outside the done state");

    a_cfg_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we && (cfg_index == REG_COLUMNS_IN_USE || cfg_index == REG_ROWS_IN_USE)
        |=> state_reg == S_CLEAR && cursor_x_reg == '0 && cursor_y_reg == '0)
        else $error("register write did not start a clear with the cursor homed");

endmodule

`default_nettype wire

[rtl/core/tcb_cell_ram.sv]
// Character cell storage: one write port and one registered read port.
// Depends on tcb_pkg for the cell width and the default address width.
`default_nettype none

module tcb_cell_ram import tcb_pkg::*; #(
    parameter int AW = CELL_AW_DEFAULT
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [CHAR_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [CHAR_W-1:0] rd_data
);

    localparam int DEPTH = 1 << AW;

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds between reads, so a result may wait on it.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/core/tcb_cursor_alu.sv]
// Shared cursor arithmetic: increments, decrements and compares against the grid size.
// Used by the sequencer for cursor moves and for walking a row. Depends on tcb_pkg.
`default_nettype none

module tcb_cursor_alu import tcb_pkg::*; #(
    parameter int MAX_COLS = MAX_COLS_DEFAULT,
    parameter int MAX_ROWS = MAX_ROWS_DEFAULT,
    parameter int TAB_STOP = TAB_STOP_DEFAULT
) (
    input  alu_op_t                         op,
    input  logic [$clog2(MAX_COLS)-1:0]     x_in,
    input  logic [$clog2(MAX_ROWS)-1:0]     y_in,
    input  logic [$clog2(MAX_COLS+1)-1:0]   cols,
    input  logic [$clog2(MAX_ROWS+1)-1:0]   rows,
    output logic [$clog2(MAX_COLS)-1:0]     x_out,
    output logic [$clog2(MAX_ROWS)-1:0]     y_out,
    output alu_flags_t                      flags
);

    localparam int CW  = $clog2(MAX_COLS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CNW = $clog2(MAX_COLS + 1);
    localparam int RNW = $clog2(MAX_ROWS + 1);
    localparam int NX  = 1 << CW;

    // Bit i is set when column i sits on a tab stop; built by counting, not dividing.
    function automatic logic [NX-1:0] tab_marks();
        logic [NX-1:0] m;
        int            ph;
        m  = '0;
        ph = 0;
        for (int i = 0; i < NX; i++) begin
            m[i] = (ph == 0);
            ph   = (ph + 1 == TAB_STOP) ? 0 : ph + 1;
        end
        return m;
    endfunction

    localparam logic [NX-1:0] TAB_MARKS = tab_marks();

    logic [CNW-1:0] x_inc;
    logic [RNW-1:0] y_inc;
    logic           last_col;
    logic           last_row;
    logic [RW-1:0]  y_wrap;

    assign x_inc    = CNW'(x_in) + CNW'(1);
    assign y_inc    = RNW'(y_in) + RNW'(1);
    assign last_col = (x_inc >= cols);
    assign last_row = (y_inc >= rows);
    assign y_wrap   = last_row ? '0 : RW'(y_inc);

    always_comb begin
        x_out = x_in;
        y_out = y_in;
        unique case (op)
            ALU_HOLD: begin
            end
            ALU_HOME: x_out = '0;
            ALU_END:  x_out = CW'(cols - CNW'(1));
            ALU_PGUP: y_out = '0;
            ALU_PGDN: y_out = RW'(rows - RNW'(1));
            ALU_LEFT: begin
                if (x_in != '0) x_out = x_in - CW'(1);
            end
            ALU_RIGHT: begin
                if (!last_col) x_out = CW'(x_inc);
            end
            ALU_UP: begin
                if (y_in != '0) y_out = y_in - RW'(1);
            end
            ALU_DOWN: begin
                if (!last_row) y_out = RW'(y_inc);
            end
            ALU_ADVANCE: begin
                if (last_col) begin
                    x_out = '0;
                    y_out = y_wrap;
                end else begin
                    x_out = CW'(x_inc);
                end
            end
            ALU_NEWLINE: y_out = y_wrap;
            ALU_RETURN: begin
                x_out = '0;
                y_out = y_wrap;
            end
            default: begin
            end
        endcase
    end

    assign flags.at_last_col = last_col;
    assign flags.tab_aligned = TAB_MARKS[x_out];

endmodule

`default_nettype wire
